// ===== design/ulbp_pkg.sv =====
package ulbp_pkg;

    // Frame limits and derived widths
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int DIM_W      = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1);
    localparam int CNT_W      = DIM_W + 1;

    // Fixed field widths
    localparam int PIX_W      = 8;
    localparam int CODE_W     = 6;
    localparam int OUT_COL_W  = 11;
    localparam int OUT_ROW_W  = 11;
    localparam int SIZE_W     = 12;
    localparam int CFG_IDX_W  = 2;

    localparam int RESET_SIZE = 64;
    localparam int MIN_SIZE   = 2;
    localparam int BIN_MAX    = 58;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    typedef logic [255:0][CODE_W-1:0] t_bin_table;

    // Pixel and line-store data handed from the line store to the code sequencer
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [PIX_W-1:0] above;
        logic [PIX_W-1:0] two_above;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last_col;
        logic             last_row;
    } t_col_item;

    // Uniform patterns (at most two circular transitions) get bins 1..58 in code order
    function automatic t_bin_table build_bins();
        t_bin_table  tbl;
        logic [7:0]  v;
        logic [7:0]  x;
        int          n;
        int          nxt;
        begin
            nxt = 1;
            for (int i = 0; i < 256; i++) begin
                v = 8'(i);
                x = v ^ {v[6:0], v[7]};
                n = 0;
                for (int b = 0; b < 8; b++) begin
                    n = n + int'(x[b]);
                end
                if (n <= 2) begin
                    tbl[i] = CODE_W'(nxt);
                    nxt = nxt + 1;
                end else begin
                    tbl[i] = '0;
                end
            end
            return tbl;
        end
    endfunction

    localparam t_bin_table BIN_TABLE = build_bins();

    // Limit a frame dimension to 2..maxv
    function automatic logic [DIM_W-1:0] clamp_size(input logic [SIZE_W-1:0] v, input int maxv);
        logic [31:0] ext;
        begin
            ext = 32'(v);
            if (ext < 32'(MIN_SIZE)) begin
                ext = 32'(MIN_SIZE);
            end else if (ext > 32'(maxv)) begin
                ext = 32'(maxv);
            end
            return DIM_W'(ext);
        end
    endfunction

endpackage

// ===== design/ulbp_if.sv =====
interface ulbp_pix_if;
    logic                       valid;
    logic                       ready;
    logic [ulbp_pkg::PIX_W-1:0] pixel;
    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface ulbp_res_if;
    logic                           valid;
    logic                           ready;
    logic [ulbp_pkg::CODE_W-1:0]    lbp_code;
    logic [ulbp_pkg::OUT_COL_W-1:0] out_col;
    logic [ulbp_pkg::OUT_ROW_W-1:0] out_row;
    logic                           frame_end;
    logic                           run_end;
    modport source (output valid, output lbp_code, output out_col, output out_row,
                    output frame_end, output run_end, input ready);
    modport sink   (input valid, input lbp_code, input out_col, input out_row,
                    input frame_end, input run_end, output ready);
endinterface

interface ulbp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ulbp_pkg::CFG_IDX_W-1:0] index;
    logic [ulbp_pkg::SIZE_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/ulbp_ram.sv =====
module ulbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/ulbp_line_store.sv =====
module ulbp_line_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ulbp_pix_if.sink                      i_pix,
    input  logic [ulbp_pkg::DIM_W-1:0]    i_width,
    input  logic [ulbp_pkg::DIM_W-1:0]    i_height,
    output logic                          o_item_valid,
    output ulbp_pkg::t_col_item           o_item,
    input  logic                          i_item_take
);

    logic                           accept;
    logic                           s1_move;
    logic                           n_last_col;
    logic                           n_last_row;
    logic [ulbp_pkg::COL_W-1:0]     n_col;
    logic [ulbp_pkg::ROW_W-1:0]     n_row;
    logic [ulbp_pkg::PIX_W-1:0]     above_rd;
    logic [ulbp_pkg::PIX_W-1:0]     two_above_rd;

    logic [ulbp_pkg::COL_W-1:0]     r_col;
    logic [ulbp_pkg::ROW_W-1:0]     r_row;
    logic                           r_s1_valid;
    logic [ulbp_pkg::PIX_W-1:0]     r_s1_pix;
    logic [ulbp_pkg::COL_W-1:0]     r_s1_col;
    logic [ulbp_pkg::ROW_W-1:0]     r_s1_row;
    logic                           r_s1_last_col;
    logic                           r_s1_last_row;

    assign s1_move     = r_s1_valid && i_item_take;
    assign i_pix.ready = !r_s1_valid || s1_move;
    assign accept      = i_pix.valid && i_pix.ready;

    // Row and column end for the pixel at the counters
    always_comb begin
        n_last_col = (ulbp_pkg::CNT_W'(r_col) + ulbp_pkg::CNT_W'(1))
                     >= ulbp_pkg::CNT_W'(i_width);
        n_last_row = (ulbp_pkg::CNT_W'(r_row) + ulbp_pkg::CNT_W'(1))
                     >= ulbp_pkg::CNT_W'(i_height);
        n_col = r_col + ulbp_pkg::COL_W'(1);
        n_row = r_row + ulbp_pkg::ROW_W'(1);
        if (n_last_col) begin
            n_col = '0;
            if (n_last_row) begin
                n_row = '0;
            end
        end else begin
            n_row = r_row;
        end
    end

    // Advance the raster position and hold the pixel while its line-store read completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_s1_pix      <= i_pix.pixel;
            r_s1_col      <= r_col;
            r_s1_row      <= r_row;
            r_s1_last_col <= n_last_col;
            r_s1_last_row <= n_last_row;
        end
    end

    // Read both rows at acceptance; write back when the pixel moves on.
    // Consecutive pixels never share a column, and a column comes back only
    // after its write has landed, so no forwarding is needed.
    ulbp_ram #(
        .WIDTH (ulbp_pkg::PIX_W),
        .DEPTH (ulbp_pkg::MAX_WIDTH)
    ) u_row_above (
        .i_clk   (i_clk),
        .i_we    (s1_move),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_pix),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (above_rd)
    );

    ulbp_ram #(
        .WIDTH (ulbp_pkg::PIX_W),
        .DEPTH (ulbp_pkg::MAX_WIDTH)
    ) u_row_two_above (
        .i_clk   (i_clk),
        .i_we    (s1_move),
        .i_waddr (r_s1_col),
        .i_wdata (above_rd),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (two_above_rd)
    );

    assign o_item_valid       = r_s1_valid;
    assign o_item.pix         = r_s1_pix;
    assign o_item.above       = above_rd;
    assign o_item.two_above   = two_above_rd;
    assign o_item.col         = r_s1_col;
    assign o_item.row         = r_s1_row;
    assign o_item.last_col    = r_s1_last_col;
    assign o_item.last_row    = r_s1_last_row;

endmodule

// ===== design/ulbp_code_seq.sv =====
module ulbp_code_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_item_valid,
    input  ulbp_pkg::t_col_item  i_item,
    output logic                 o_item_take,
    ulbp_res_if.source           o_res
);

    typedef enum logic [1:0] {
        KIND_UPPER_LEFT,
        KIND_UPPER_RIGHT,
        KIND_LOWER_LEFT,
        KIND_LOWER_RIGHT
    } t_kind;

    logic [ulbp_pkg::PIX_W-1:0]     r_win [3][3];
    logic                           r_s2_valid;
    t_kind                          r_kind;
    logic [ulbp_pkg::COL_W-1:0]     r_s2_col;
    logic [ulbp_pkg::ROW_W-1:0]     r_s2_row;
    logic                           r_s2_last_col;
    logic                           r_s2_last_row;

    logic                           r_out_valid;
    logic [ulbp_pkg::CODE_W-1:0]    r_out_code;
    logic [ulbp_pkg::OUT_COL_W-1:0] r_out_col;
    logic [ulbp_pkg::OUT_ROW_W-1:0] r_out_row;
    logic                           r_out_frame_end;
    logic                           r_out_run_end;

    logic                           load;
    logic                           out_load;
    logic                           s2_last;
    t_kind                          n_kind;
    logic [1:0]                     t_sel;
    logic [1:0]                     m_sel;
    logic [1:0]                     b_sel;
    logic [1:0]                     l_sel;
    logic [1:0]                     c_sel;
    logic [1:0]                     r_sel;
    logic [ulbp_pkg::PIX_W-1:0]     ctr;
    logic [7:0]                     pattern;
    logic [ulbp_pkg::COL_W-1:0]     res_col;
    logic [ulbp_pkg::ROW_W-1:0]     res_row;

    assign out_load    = r_s2_valid && (!r_out_valid || o_res.ready);
    assign o_item_take = !r_s2_valid || (out_load && s2_last);
    assign load        = i_item_valid && o_item_take;

    // Pick the next result of this pixel
    always_comb begin
        n_kind  = r_kind;
        s2_last = 1'b1;
        unique case (r_kind)
            KIND_UPPER_LEFT: begin
                if (r_s2_last_col) begin
                    n_kind  = KIND_UPPER_RIGHT;
                    s2_last = 1'b0;
                end else if (r_s2_last_row) begin
                    n_kind  = KIND_LOWER_LEFT;
                    s2_last = 1'b0;
                end
            end
            KIND_UPPER_RIGHT: begin
                if (r_s2_last_row) begin
                    n_kind  = KIND_LOWER_LEFT;
                    s2_last = 1'b0;
                end
            end
            KIND_LOWER_LEFT: begin
                if (r_s2_last_col) begin
                    n_kind  = KIND_LOWER_RIGHT;
                    s2_last = 1'b0;
                end
            end
            KIND_LOWER_RIGHT: begin
                s2_last = 1'b1;
            end
            default: begin
                s2_last = 1'b1;
            end
        endcase
    end

    // Choose the reflected window rows and columns and form the pattern
    always_comb begin
        if (r_kind == KIND_UPPER_LEFT || r_kind == KIND_UPPER_RIGHT) begin
            // top row of the frame reflects onto the row below
            t_sel   = (r_s2_row == ulbp_pkg::ROW_W'(1)) ? 2'd2 : 2'd0;
            m_sel   = 2'd1;
            b_sel   = 2'd2;
            res_row = r_s2_row - ulbp_pkg::ROW_W'(1);
        end else begin
            // bottom row of the frame reflects onto the row above
            t_sel   = 2'd1;
            m_sel   = 2'd2;
            b_sel   = 2'd1;
            res_row = r_s2_row;
        end
        if (r_kind == KIND_UPPER_LEFT || r_kind == KIND_LOWER_LEFT) begin
            // left edge reflects onto the column to the right
            l_sel   = (r_s2_col == ulbp_pkg::COL_W'(1)) ? 2'd2 : 2'd0;
            c_sel   = 2'd1;
            r_sel   = 2'd2;
            res_col = r_s2_col - ulbp_pkg::COL_W'(1);
        end else begin
            // right edge reflects onto the column to the left
            l_sel   = 2'd1;
            c_sel   = 2'd2;
            r_sel   = 2'd1;
            res_col = r_s2_col;
        end
        ctr        = r_win[m_sel][c_sel];
        pattern[7] = r_win[t_sel][l_sel] >= ctr;
        pattern[6] = r_win[t_sel][c_sel] >= ctr;
        pattern[5] = r_win[t_sel][r_sel] >= ctr;
        pattern[4] = r_win[m_sel][r_sel] >= ctr;
        pattern[3] = r_win[b_sel][r_sel] >= ctr;
        pattern[2] = r_win[b_sel][c_sel] >= ctr;
        pattern[1] = r_win[b_sel][l_sel] >= ctr;
        pattern[0] = r_win[m_sel][l_sel] >= ctr;
    end

    // Shift the window on every pixel and step through its results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
            r_s2_valid <= 1'b0;
            r_kind     <= KIND_UPPER_LEFT;
        end else begin
            if (load) begin
                for (int i = 0; i < 3; i++) begin
                    r_win[i][0] <= r_win[i][1];
                    r_win[i][1] <= r_win[i][2];
                end
                r_win[0][2] <= i_item.two_above;
                r_win[1][2] <= i_item.above;
                r_win[2][2] <= i_item.pix;
                r_s2_valid  <= (i_item.row != '0) && (i_item.col != '0);
                r_kind      <= KIND_UPPER_LEFT;
            end else if (out_load) begin
                if (s2_last) begin
                    r_s2_valid <= 1'b0;
                end else begin
                    r_kind <= n_kind;
                end
            end
        end
        if (load) begin
            r_s2_col      <= i_item.col;
            r_s2_row      <= i_item.row;
            r_s2_last_col <= i_item.last_col;
            r_s2_last_row <= i_item.last_row;
        end
    end

    // Output register: hold until transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (out_load) begin
            r_out_code      <= ulbp_pkg::BIN_TABLE[pattern];
            r_out_col       <= ulbp_pkg::OUT_COL_W'(res_col);
            r_out_row       <= ulbp_pkg::OUT_ROW_W'(res_row);
            r_out_frame_end <= (r_kind == KIND_LOWER_RIGHT);
            r_out_run_end   <= s2_last;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.lbp_code  = r_out_code;
    assign o_res.out_col   = r_out_col;
    assign o_res.out_row   = r_out_row;
    assign o_res.frame_end = r_out_frame_end;
    assign o_res.run_end   = r_out_run_end;

endmodule

// ===== design/uniform_lbp_pixel_stream.sv =====
// Path: a pixel passes the line-store, window and output registers before its first result.
// Throughput: one pixel per cycle while o_res is ready; a pixel that ends a row or lies in the
// last row holds the input while its extra results (up to three) go out, as the single code
// unit emits one result per cycle. The line stores take one read and one write per cycle.
// Reset: counters, window and output clear, sizes return to 64x64; line stores are not cleared.
module uniform_lbp_pixel_stream (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ulbp_pix_if.sink    i_pix,
    ulbp_cfg_if.sink    i_cfg,
    ulbp_res_if.source  o_res
);

    logic [ulbp_pkg::DIM_W-1:0] r_width;
    logic [ulbp_pkg::DIM_W-1:0] r_height;
    logic                       item_valid;
    logic                       item_take;
    ulbp_pkg::t_col_item        item;

    assign i_cfg.ready = 1'b1;

    // Hold the clamped frame size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= ulbp_pkg::clamp_size(ulbp_pkg::SIZE_W'(ulbp_pkg::RESET_SIZE),
                                             ulbp_pkg::MAX_WIDTH);
            r_height <= ulbp_pkg::clamp_size(ulbp_pkg::SIZE_W'(ulbp_pkg::RESET_SIZE),
                                             ulbp_pkg::MAX_HEIGHT);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                ulbp_pkg::REG_IMAGE_WIDTH: begin
                    r_width <= ulbp_pkg::clamp_size(i_cfg.data, ulbp_pkg::MAX_WIDTH);
                end
                ulbp_pkg::REG_IMAGE_HEIGHT: begin
                    r_height <= ulbp_pkg::clamp_size(i_cfg.data, ulbp_pkg::MAX_HEIGHT);
                end
                default: begin
                    r_width <= r_width;
                end
            endcase
        end
    end

    ulbp_line_store u_line_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (i_pix),
        .i_width      (r_width),
        .i_height     (r_height),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_item_take  (item_take)
    );

    ulbp_code_seq u_code_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_take  (item_take),
        .o_res        (o_res)
    );

endmodule

// ===== design/ulbp_checker.sv =====
module ulbp_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [ulbp_pkg::CODE_W-1:0]    i_lbp_code,
    input logic [ulbp_pkg::OUT_COL_W-1:0] i_out_col,
    input logic [ulbp_pkg::OUT_ROW_W-1:0] i_out_row,
    input logic                           i_frame_end,
    input logic                           i_run_end
);

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
            && $stable({i_lbp_code, i_out_col, i_out_row, i_frame_end, i_run_end}))
        else $error("result changed while stalled");

    // The last code of a frame closes its run
    a_frame_end_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_frame_end |-> i_run_end)
        else $error("frame end without run end");

    // Bins stay within the uniform table
    a_bin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_lbp_code <= ulbp_pkg::CODE_W'(ulbp_pkg::BIN_MAX)))
        else $error("bin out of range");

    // A run continues in the next cycle once a non-final result transfers
    a_run_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_run_end |=> i_out_valid)
        else $error("gap inside a run");

    // Reset clears the output
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind uniform_lbp_pixel_stream ulbp_checker u_ulbp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_lbp_code  (o_res.lbp_code),
    .i_out_col   (o_res.out_col),
    .i_out_row   (o_res.out_row),
    .i_frame_end (o_res.frame_end),
    .i_run_end   (o_res.run_end)
);
